// File: design/brus_pkg.sv
// Shared types and constants of the bitmap range update and scan unit.
package brus_pkg;

  localparam int POS_W = 10;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_FLIP  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clear;
    logic start;
    logic issue;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic iss_last;
    logic size_zero;
  } dp_sts_t;

endpackage

// File: design/brus_ctrl.sv
// Controller state machine of the bitmap range update and scan unit.
module brus_ctrl import brus_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.size_zero ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.iss_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.clear = (state_q == ST_CLEAR);
    cmd_o.start = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue = (state_q == ST_SCAN);
    cmd_o.load  = (state_q == ST_FINISH) && out_free;
    out_valid_d = cmd_o.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/brus_dp.sv
// Datapath of the bitmap range update and scan unit: word memory, update and scan logic.
module brus_dp import brus_pkg::*; #(
  parameter int MAX_BITS  = 256,
  parameter int WORD_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_write_i,
  input  logic [8:0] cfg_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] start_req_i,
  input  logic [8:0] run_length_i,
  output logic       bit_at_start_o,
  output logic [7:0] first_set_o,
  output logic       first_set_found_o,
  output logic [7:0] first_clear_o,
  output logic       first_clear_found_o,
  output logic [7:0] last_set_o,
  output logic       last_set_found_o,
  output logic [7:0] last_clear_o,
  output logic       last_clear_found_o,
  output logic [8:0] set_count_o,
  output logic       all_set_o
);

  localparam int WordCount = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WaW       = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int BiW       = $clog2(WORD_BITS);
  localparam int PcW       = $clog2(WORD_BITS + 1);
  localparam int SizeCap   = (MAX_BITS < 511) ? MAX_BITS : 511;

  logic [8:0]           active_q;
  logic [WORD_BITS-1:0] mem_q [WordCount];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WaW-1:0]       iss_addr_q, proc_addr_q;
  pos_t                 iss_base_q, proc_base_q;
  logic                 proc_vld_q;
  op_e                  op_q;
  pos_t                 start_q, end_q;

  pos_t size, end_raw, end_cl;

  logic [WORD_BITS-1:0] run_m, use_m, hit_m, word_new, ones_m, zeros_m;
  logic [BiW-1:0]       fs_idx, ls_idx, fc_idx, lc_idx;
  logic [PcW-1:0]       pop;
  logic                 at_hit, at_val;
  pos_t                 bpos;

  logic fs_found_q, fc_found_q, ls_found_q, lc_found_q, at_q;
  pos_t fs_q, fc_q, ls_q, lc_q, count_q;

  assign size    = (int'(active_q) > SizeCap) ? POS_W'(SizeCap) : POS_W'(active_q);
  assign end_raw = POS_W'(start_req_i) + POS_W'(run_length_i);
  assign end_cl  = (end_raw > size) ? size : end_raw;

  assign sts_o.size_zero = (size == '0);
  assign sts_o.iss_last  = ((iss_base_q + POS_W'(WORD_BITS)) >= size);
  assign sts_o.clr_last  = (iss_addr_q == WaW'(WordCount - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 9'd256;
    end else if (cfg_write_i) begin
      active_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[iss_addr_q] <= '0;
    end else if (proc_vld_q && (op_q != OP_QUERY)) begin
      mem_q[proc_addr_q] <= word_new;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[iss_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_addr_q <= '0;
      iss_base_q <= '0;
      proc_vld_q <= 1'b0;
    end else begin
      proc_vld_q <= cmd_i.issue;
      if (cmd_i.clear) begin
        iss_addr_q <= iss_addr_q + WaW'(1);
      end else if (cmd_i.start) begin
        iss_addr_q <= '0;
        iss_base_q <= '0;
      end else if (cmd_i.issue) begin
        iss_addr_q <= iss_addr_q + WaW'(1);
        iss_base_q <= iss_base_q + POS_W'(WORD_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_addr_q <= iss_addr_q;
    proc_base_q <= iss_base_q;
    if (cmd_i.start) begin
      op_q    <= op_e'(opcode_i);
      start_q <= POS_W'(start_req_i);
      end_q   <= end_cl;
    end
  end

  always_comb begin
    bpos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      bpos     = proc_base_q + POS_W'(b);
      run_m[b] = (bpos >= start_q) && (bpos < end_q);
      use_m[b] = (bpos < size);
      hit_m[b] = (bpos == start_q);
    end
    unique case (op_q)
      OP_CLEAR: word_new = rdata_q & ~run_m;
      OP_SET:   word_new = rdata_q | run_m;
      OP_FLIP:  word_new = rdata_q ^ run_m;
      OP_QUERY: word_new = rdata_q;
      default:  word_new = rdata_q;
    endcase
    ones_m  = word_new & use_m;
    zeros_m = ~word_new & use_m;
    fs_idx  = '0;
    fc_idx  = '0;
    ls_idx  = '0;
    lc_idx  = '0;
    pop     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (ones_m[b]) fs_idx = BiW'(b);
      if (zeros_m[b]) fc_idx = BiW'(b);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (ones_m[b]) ls_idx = BiW'(b);
      if (zeros_m[b]) lc_idx = BiW'(b);
      pop = pop + PcW'(ones_m[b]);
    end
    at_hit = |(hit_m & use_m);
    at_val = |(hit_m & word_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_found_q <= 1'b0;
      fc_found_q <= 1'b0;
      ls_found_q <= 1'b0;
      lc_found_q <= 1'b0;
      at_q       <= 1'b0;
      fs_q       <= '0;
      fc_q       <= '0;
      ls_q       <= '0;
      lc_q       <= '0;
      count_q    <= '0;
    end else if (cmd_i.start) begin
      fs_found_q <= 1'b0;
      fc_found_q <= 1'b0;
      ls_found_q <= 1'b0;
      lc_found_q <= 1'b0;
      at_q       <= 1'b0;
      fs_q       <= '0;
      fc_q       <= '0;
      ls_q       <= '0;
      lc_q       <= '0;
      count_q    <= '0;
    end else if (proc_vld_q) begin
      if (|ones_m) begin
        if (!fs_found_q) begin
          fs_q       <= proc_base_q + POS_W'(fs_idx);
          fs_found_q <= 1'b1;
        end
        ls_q       <= proc_base_q + POS_W'(ls_idx);
        ls_found_q <= 1'b1;
      end
      if (|zeros_m) begin
        if (!fc_found_q) begin
          fc_q       <= proc_base_q + POS_W'(fc_idx);
          fc_found_q <= 1'b1;
        end
        lc_q       <= proc_base_q + POS_W'(lc_idx);
        lc_found_q <= 1'b1;
      end
      count_q <= count_q + POS_W'(pop);
      if (at_hit) at_q <= at_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bit_at_start_o      <= at_q;
      first_set_o         <= fs_q[7:0];
      first_set_found_o   <= fs_found_q;
      first_clear_o       <= fc_q[7:0];
      first_clear_found_o <= fc_found_q;
      last_set_o          <= ls_q[7:0];
      last_set_found_o    <= ls_found_q;
      last_clear_o        <= lc_q[7:0];
      last_clear_found_o  <= lc_found_q;
      set_count_o         <= count_q[8:0];
      all_set_o           <= (size != '0) && (count_q == size);
    end
  end

endmodule

// File: design/bitmap_range_update_and_scan_unit.sv
// Top level of the bitmap range update and scan unit.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_data_i (active_bits)
//   in       in         in_valid_i/in_ready_o    opcode_i, start_req_i, run_length_i
//   out      out        out_valid_o/out_ready_i  bit_at_start_o ... all_set_o
//
// A request scans ceil(size / WORD_BITS) words, where size is active_bits clipped
// to MAX_BITS, and no word when size is zero; the scan is bound by the single memory port
// that reads one word per cycle.
// After reset a clearing pass zeroes the word memory word by word (32 words at the
// default sizes); no request is taken during that pass.
// A finished result waits in the output register while the next request is taken.
// Configuration writes are taken in every cycle.
module bitmap_range_update_and_scan_unit import brus_pkg::*; #(
  parameter int MAX_BITS  = 256,
  parameter int WORD_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] start_req_i,
  input  logic [8:0] run_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bit_at_start_o,
  output logic [7:0] first_set_o,
  output logic       first_set_found_o,
  output logic [7:0] first_clear_o,
  output logic       first_clear_found_o,
  output logic [7:0] last_set_o,
  output logic       last_set_found_o,
  output logic [7:0] last_clear_o,
  output logic       last_clear_found_o,
  output logic [8:0] set_count_o,
  output logic       all_set_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  brus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brus_dp #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_write_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .opcode_i            (opcode_i),
    .start_req_i         (start_req_i),
    .run_length_i        (run_length_i),
    .bit_at_start_o      (bit_at_start_o),
    .first_set_o         (first_set_o),
    .first_set_found_o   (first_set_found_o),
    .first_clear_o       (first_clear_o),
    .first_clear_found_o (first_clear_found_o),
    .last_set_o          (last_set_o),
    .last_set_found_o    (last_set_found_o),
    .last_clear_o        (last_clear_o),
    .last_clear_found_o  (last_clear_found_o),
    .set_count_o         (set_count_o),
    .all_set_o           (all_set_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.clear |-> !in_ready_o)
    else $error("request taken during the clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_set_o) |-> (first_set_found_o && !first_clear_found_o))
    else $error("full map reported with a clear bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !first_set_found_o) |-> (set_count_o == 9'd0))
    else $error("ones counted with no set bit found");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap range update and scan unit.
module testbench import brus_pkg::*; ();

  typedef struct packed {
    logic       bit_at_start;
    logic [7:0] first_set;
    logic       first_set_found;
    logic [7:0] first_clear;
    logic       first_clear_found;
    logic [7:0] last_set;
    logic       last_set_found;
    logic [7:0] last_clear;
    logic       last_clear_found;
    logic [8:0] set_count;
    logic       all_set;
  } scan_result_t;

  typedef struct {
    bit           size_write;
    logic [8:0]   size_value;
    op_e          op;
    logic [7:0]   start;
    logic [8:0]   length;
    bit           fixed;
    scan_result_t result;
  } directed_row_t;

  localparam scan_result_t EMPTY_MAP =
    {1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd255, 1'b1, 9'd0, 1'b0};
  localparam scan_result_t FULL_MAP =
    {1'b1, 8'd0, 1'b1, 8'd0, 1'b0, 8'd255, 1'b1, 8'd0, 1'b0, 9'd256, 1'b1};
  localparam scan_result_t TOP_CLEARED =
    {1'b0, 8'd0, 1'b1, 8'd255, 1'b1, 8'd254, 1'b1, 8'd255, 1'b1, 9'd255, 1'b0};
  localparam scan_result_t TOP_CLEARED_AT_ZERO =
    {1'b1, 8'd0, 1'b1, 8'd255, 1'b1, 8'd254, 1'b1, 8'd255, 1'b1, 9'd255, 1'b0};
  localparam scan_result_t NOTHING_IN_USE = '0;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [8:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] opcode_i;
  logic [7:0] start_req_i;
  logic [8:0] run_length_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       bit_at_start_o;
  logic [7:0] first_set_o;
  logic       first_set_found_o;
  logic [7:0] first_clear_o;
  logic       first_clear_found_o;
  logic [7:0] last_set_o;
  logic       last_set_found_o;
  logic [7:0] last_clear_o;
  logic       last_clear_found_o;
  logic [8:0] set_count_o;
  logic       all_set_o;

  logic [255:0]  bitmap_model;
  logic [8:0]    active_size;
  scan_result_t  pending_results[$];
  scan_result_t  fixed_result;
  bit            fixed_pending;
  scan_result_t  observed;
  scan_result_t  wanted;
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   sender_idle_pct;
  int unsigned   receiver_stall_pct;
  directed_row_t directed_rows[$];

  bitmap_range_update_and_scan_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .start_req_i         (start_req_i),
    .run_length_i        (run_length_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .bit_at_start_o      (bit_at_start_o),
    .first_set_o         (first_set_o),
    .first_set_found_o   (first_set_found_o),
    .first_clear_o       (first_clear_o),
    .first_clear_found_o (first_clear_found_o),
    .last_set_o          (last_set_o),
    .last_set_found_o    (last_set_found_o),
    .last_clear_o        (last_clear_o),
    .last_clear_found_o  (last_clear_found_o),
    .set_count_o         (set_count_o),
    .all_set_o           (all_set_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = ~clk_i;
  end

  function automatic scan_result_t apply_and_scan(op_e op, logic [7:0] start,
                                                   logic [8:0] length);
    int unsigned  span;
    int unsigned  pos;
    int unsigned  ones;
    scan_result_t r;
    span = (active_size > 9'd256) ? 256 : active_size;
    ones = 0;
    r = '0;
    if (op != OP_QUERY) begin
      for (int unsigned i = 0; i < length; i++) begin
        pos = start + i;
        if (pos < span) begin
          case (op)
            OP_CLEAR: bitmap_model[pos] = 1'b0;
            OP_SET:   bitmap_model[pos] = 1'b1;
            default:  bitmap_model[pos] = ~bitmap_model[pos];
          endcase
        end
      end
    end
    r.bit_at_start = (start < span) ? bitmap_model[start] : 1'b0;
    for (pos = 0; pos < span; pos++) begin
      if (bitmap_model[pos]) begin
        ones++;
        if (!r.first_set_found) begin
          r.first_set       = 8'(pos);
          r.first_set_found = 1'b1;
        end
        r.last_set       = 8'(pos);
        r.last_set_found = 1'b1;
      end else begin
        if (!r.first_clear_found) begin
          r.first_clear       = 8'(pos);
          r.first_clear_found = 1'b1;
        end
        r.last_clear       = 8'(pos);
        r.last_clear_found = 1'b1;
      end
    end
    r.set_count = 9'(ones);
    r.all_set   = (span != 0) && (ones == span);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      observed = {bit_at_start_o, first_set_o, first_set_found_o, first_clear_o,
                  first_clear_found_o, last_set_o, last_set_found_o, last_clear_o,
                  last_clear_found_o, set_count_o, all_set_o};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        wanted = pending_results.pop_front();
        check_field("bit_at_start", 9'(observed.bit_at_start), 9'(wanted.bit_at_start));
        check_field("first_set", 9'(observed.first_set), 9'(wanted.first_set));
        check_field("first_set_found", 9'(observed.first_set_found),
                    9'(wanted.first_set_found));
        check_field("first_clear", 9'(observed.first_clear), 9'(wanted.first_clear));
        check_field("first_clear_found", 9'(observed.first_clear_found),
                    9'(wanted.first_clear_found));
        check_field("last_set", 9'(observed.last_set), 9'(wanted.last_set));
        check_field("last_set_found", 9'(observed.last_set_found),
                    9'(wanted.last_set_found));
        check_field("last_clear", 9'(observed.last_clear), 9'(wanted.last_clear));
        check_field("last_clear_found", 9'(observed.last_clear_found),
                    9'(wanted.last_clear_found));
        check_field("set_count", observed.set_count, wanted.set_count);
        check_field("all_set", 9'(observed.all_set), 9'(wanted.all_set));
      end
      results_seen++;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      active_size = cfg_data_i;
    end
    if (in_valid_i && in_ready_o) begin
      wanted = apply_and_scan(op_e'(opcode_i), start_req_i, run_length_i);
      pending_results.push_back(fixed_pending ? fixed_result : wanted);
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_request(op_e op, logic [7:0] start, logic [8:0] length,
                              bit fixed, scan_result_t result);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    fixed_pending = fixed;
    fixed_result  = result;
    in_valid_i    = 1'b1;
    opcode_i      = op;
    start_req_i   = start;
    run_length_i  = length;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_active_bits(logic [8:0] value);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic directed_row_t make_row(bit size_write, logic [8:0] size_value, op_e op,
                                             logic [7:0] start, logic [8:0] length,
                                             bit fixed, scan_result_t result);
    directed_row_t row;
    row.size_write = size_write;
    row.size_value = size_value;
    row.op         = op;
    row.start      = start;
    row.length     = length;
    row.fixed      = fixed;
    row.result     = result;
    return row;
  endfunction

  initial begin
    logic [8:0] phase_sizes[12];
    int unsigned span;
    int unsigned pick;
    op_e         op;
    logic [7:0]  start;
    logic [8:0]  length;

    phase_sizes = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd8, 9'd37,
                    9'd257, 9'd200, 9'd256, 9'd130, 9'd9, 9'd64};
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    opcode_i           = OP_QUERY;
    start_req_i        = '0;
    run_length_i       = '0;
    out_ready_i        = 1'b1;
    bitmap_model       = '0;
    active_size        = 9'd256;
    fixed_pending      = 1'b0;
    fixed_result       = '0;
    mismatches         = 0;
    results_seen       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    directed_rows.push_back(make_row(0, 0, OP_QUERY, 0, 0, 1, EMPTY_MAP));
    directed_rows.push_back(make_row(0, 0, OP_SET, 0, 256, 1, FULL_MAP));
    directed_rows.push_back(make_row(0, 0, OP_CLEAR, 255, 511, 1, TOP_CLEARED));
    directed_rows.push_back(make_row(0, 0, OP_FLIP, 0, 0, 1, TOP_CLEARED_AT_ZERO));
    directed_rows.push_back(make_row(0, 0, OP_FLIP, 128, 8, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_CLEAR, 0, 1, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_QUERY, 200, 0, 0, '0));
    directed_rows.push_back(make_row(1, 0, OP_QUERY, 0, 0, 1, NOTHING_IN_USE));
    directed_rows.push_back(make_row(0, 0, OP_SET, 0, 511, 1, NOTHING_IN_USE));
    directed_rows.push_back(make_row(1, 1, OP_FLIP, 0, 1, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_QUERY, 1, 3, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_SET, 255, 256, 0, '0));
    directed_rows.push_back(make_row(1, 511, OP_QUERY, 255, 0, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_FLIP, 250, 256, 0, '0));
    directed_rows.push_back(make_row(1, 257, OP_SET, 17, 40, 0, '0));
    directed_rows.push_back(make_row(1, 9, OP_SET, 3, 300, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_CLEAR, 8, 1, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_FLIP, 0, 511, 0, '0));
    directed_rows.push_back(make_row(1, 256, OP_CLEAR, 0, 256, 1, EMPTY_MAP));
    directed_rows.push_back(make_row(0, 0, OP_SET, 255, 1, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_QUERY, 255, 0, 0, '0));
    directed_rows.push_back(make_row(0, 0, OP_FLIP, 0, 256, 0, '0));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].size_write) begin
        write_active_bits(directed_rows[i].size_value);
      end
      send_request(directed_rows[i].op, directed_rows[i].start, directed_rows[i].length,
                   directed_rows[i].fixed, directed_rows[i].result);
    end

    foreach (phase_sizes[p]) begin
      write_active_bits(phase_sizes[p]);
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 86;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 86;
        end
        default: begin
          sender_idle_pct    = 34;
          receiver_stall_pct = 34;
        end
      endcase
      span = (phase_sizes[p] > 9'd256) ? 256 : phase_sizes[p];
      repeat (125) begin
        pick = $urandom_range(99);
        op   = op_e'($urandom_range(3));
        if (pick < 10 || span == 0) begin
          start  = 8'($urandom_range(255));
          length = 9'($urandom_range(511));
        end else if (pick < 16) begin
          op     = op_e'($urandom_range(2));
          start  = '0;
          length = $urandom_range(1) ? 9'd256 : 9'd511;
        end else begin
          start  = 8'($urandom_range(span - 1));
          length = $urandom_range(1) ? 9'($urandom_range(16)) : 9'($urandom_range(span));
        end
        send_request(op, start, length, 1'b0, '0);
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
    end

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("bitmap_range_update_and_scan_unit: match");
    end else begin
      $display("bitmap_range_update_and_scan_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("bitmap_range_update_and_scan_unit: mismatch");
    $finish;
  end

endmodule

// File: sim.f
design/brus_pkg.sv
design/brus_ctrl.sv
design/brus_dp.sv
design/bitmap_range_update_and_scan_unit.sv
bench/testbench.sv
